@@ src/sliding_door_cosine_motion_macros.svh @@
// assertion helpers shared by the door motion block
`ifndef SLIDING_DOOR_COSINE_MOTION_MACROS_SVH
`define SLIDING_DOOR_COSINE_MOTION_MACROS_SVH

// condition holds in the same cycle
`define SDCM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the next cycle
`define SDCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/sdcm_pkg.sv @@
package sdcm_pkg;

  localparam int unsigned COS_TABLE_DEPTH = 256;
  localparam int unsigned TIME_BITS       = 16;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [15:0] ONE_Q15 = 16'd32768;

  // taylor series divisors (2k-1)*2k for k = 1..7
  localparam logic [7:0] TAYLOR_DIV [1:7] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182};

  // config register map
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSED_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSED_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OPENED_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OPENED_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_DURATION = 3'd4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [15:0] DURATION_RESET = 16'd1000;

  typedef enum logic [1:0] {
    DOOR_SHUT    = 2'd0,
    DOOR_TO_OPEN = 2'd1,
    DOOR_OPEN    = 2'd2,
    DOOR_TO_SHUT = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_OPEN  = 2'd1,
    REQ_CLOSE = 2'd2
  } req_e;

  // microcode operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_TAKE,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_ALPHA,
    OP_MUL_X,
    OP_SUM_X,
    OP_MUL_Y,
    OP_SUM_Y,
    OP_TIME,
    OP_REST,
    OP_REQ,
    OP_EMIT
  } op_e;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_NOT_TICK,
    C_AT_REST,
    C_DIV_MORE,
    C_OUT_BUSY
  } cond_e;

  localparam int unsigned PC_W = 4;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
    logic            last;
  } uword_t;

  typedef struct packed {
    logic signed [15:0] closed_x;
    logic signed [15:0] closed_y;
    logic signed [15:0] opened_x;
    logic signed [15:0] opened_y;
    logic [15:0]        move_duration;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] step_time;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] door_x;
    logic signed [15:0] door_y;
    logic [1:0]         door_mode;
  } out_word_t;

  typedef struct packed {
    logic at_rest;
    logic div_more;
  } dp_stat_t;

endpackage

@@ src/sdcm_datapath.sv @@
module sdcm_datapath #(
  parameter int unsigned TIME_BITS       = sdcm_pkg::TIME_BITS,
  parameter int unsigned COS_TABLE_DEPTH = sdcm_pkg::COS_TABLE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sdcm_pkg::op_e        op_i,
  input  sdcm_pkg::cfg_t       cfg_i,
  input  sdcm_pkg::in_word_t   word_i,
  output sdcm_pkg::dp_stat_t   stat_o,
  output sdcm_pkg::out_word_t  pos_o
);

  localparam int unsigned QB        = $clog2(COS_TABLE_DEPTH);
  localparam int unsigned ROM_DEPTH = 2 ** QB;
  localparam int unsigned NW        = TIME_BITS + QB;
  localparam int unsigned CNT_W     = $clog2(QB);
  localparam logic [NW-1:0]    DEPTH_NW = NW'(COS_TABLE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(QB - 1);

  // half-cosine weight table, entries past the depth are never addressed
  logic [15:0] cos_rom [ROM_DEPTH];

  // (cos(ang)+1)/2 in q1.15, ang in q30, reflected past pi/2, rounded half up
  for (genvar i = 0; i < ROM_DEPTH; i++) begin : g_rom
    localparam logic        USED = (i < COS_TABLE_DEPTH);
    localparam logic        REFL = USED && (2 * i > COS_TABLE_DEPTH);
    localparam int unsigned J    = !USED ? 0 : (REFL ? (COS_TABLE_DEPTH - i) : i);
    localparam logic [63:0] ANG  = (sdcm_pkg::PI_Q30 * J) / COS_TABLE_DEPTH;
    // truncated q30 taylor terms up to x^14
    localparam logic [63:0] X2   = (ANG * ANG) >> 30;
    localparam logic [63:0] T1   = (((64'd1 << 30) * X2) >> 30) /
                                   64'(sdcm_pkg::TAYLOR_DIV[1]);
    localparam logic [63:0] T2   = ((T1 * X2) >> 30) / 64'(sdcm_pkg::TAYLOR_DIV[2]);
    localparam logic [63:0] T3   = ((T2 * X2) >> 30) / 64'(sdcm_pkg::TAYLOR_DIV[3]);
    localparam logic [63:0] T4   = ((T3 * X2) >> 30) / 64'(sdcm_pkg::TAYLOR_DIV[4]);
    localparam logic [63:0] T5   = ((T4 * X2) >> 30) / 64'(sdcm_pkg::TAYLOR_DIV[5]);
    localparam logic [63:0] T6   = ((T5 * X2) >> 30) / 64'(sdcm_pkg::TAYLOR_DIV[6]);
    localparam logic [63:0] T7   = ((T6 * X2) >> 30) / 64'(sdcm_pkg::TAYLOR_DIV[7]);
    localparam logic signed [63:0] SUM  = 64'sd1073741824 - $signed(T1) + $signed(T2) -
                                          $signed(T3) + $signed(T4) - $signed(T5) +
                                          $signed(T6) - $signed(T7);
    localparam logic signed [63:0] COSV = REFL ? -SUM : SUM;
    localparam logic signed [63:0] NUM  = 64'sd1073741824 + COSV + 64'sd32768;
    localparam logic signed [63:0] CAP  = $signed({48'd0, sdcm_pkg::ONE_Q15});
    localparam logic [15:0] ENTRY = (!USED || (NUM < 0)) ? 16'd0 :
                                    (((NUM >>> 16) > CAP) ? sdcm_pkg::ONE_Q15 : NUM[31:16]);
    assign cos_rom[i] = ENTRY;
  end

  // architectural state
  sdcm_pkg::mode_e       mode_q, mode_d;
  logic signed [TIME_BITS:0] tl_q, tl_d;
  logic signed [15:0]    last_x_q, last_x_d;
  logic signed [15:0]    last_y_q, last_y_d;

  // work registers
  logic [TIME_BITS-1:0]  rem_q, rem_d;
  logic [QB-1:0]         dq_q, dq_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  sat_q, sat_d;
  logic [15:0]           alpha_q, alpha_d;
  logic signed [33:0]    prod_q, prod_d;

  logic [31:0]           dur_ext, step_ext;
  logic [TIME_BITS-1:0]  d_raw, d_w, step_w, t_w;
  logic [NW-1:0]         num_w;
  logic [TIME_BITS:0]    r2_w, r2_sub;
  logic                  ge_w;
  logic signed [TIME_BITS:0] rev_w;
  logic                  opening_w;
  logic signed [15:0]    tgt_x, tgt_y, st_x, st_y, st_sel;
  logic signed [16:0]    mul_a, mul_b;
  logic signed [33:0]    rnd_w, shr_w;
  logic signed [15:0]    pos_w;

  assign dur_ext  = {16'd0, cfg_i.move_duration};
  assign step_ext = {16'd0, word_i.step_time};
  assign d_raw    = dur_ext[TIME_BITS-1:0];
  assign d_w      = (d_raw == '0) ? {{(TIME_BITS-1){1'b0}}, 1'b1} : d_raw;
  assign step_w   = step_ext[TIME_BITS-1:0];
  assign t_w      = tl_q[TIME_BITS] ? '0 : tl_q[TIME_BITS-1:0];

  // index = t*depth/d, restoring division one quotient bit a step
  assign num_w  = NW'(t_w) * DEPTH_NW;
  assign r2_w   = {rem_q, dq_q[QB-1]};
  assign r2_sub = r2_w - {1'b0, d_w};
  assign ge_w   = (r2_w >= {1'b0, d_w});

  assign rev_w  = $signed({1'b0, d_w}) - tl_q;

  assign opening_w = (mode_q == sdcm_pkg::DOOR_TO_OPEN);
  assign tgt_x = opening_w ? cfg_i.opened_x : cfg_i.closed_x;
  assign tgt_y = opening_w ? cfg_i.opened_y : cfg_i.closed_y;
  assign st_x  = opening_w ? cfg_i.closed_x : cfg_i.opened_x;
  assign st_y  = opening_w ? cfg_i.closed_y : cfg_i.opened_y;

  // blend = start + round((target-start)*alpha / 2^15)
  assign mul_a  = (op_i == sdcm_pkg::OP_MUL_Y) ?
                  ({tgt_y[15], tgt_y} - {st_y[15], st_y}) :
                  ({tgt_x[15], tgt_x} - {st_x[15], st_x});
  assign mul_b  = $signed({1'b0, alpha_q});
  assign prod_d = mul_a * mul_b;
  assign rnd_w  = prod_q + 34'sd16384;
  assign shr_w  = rnd_w >>> 15;
  assign st_sel = (op_i == sdcm_pkg::OP_SUM_Y) ? st_y : st_x;
  assign pos_w  = st_sel + shr_w[15:0];

  always_comb begin
    mode_d   = mode_q;
    tl_d     = tl_q;
    last_x_d = last_x_q;
    last_y_d = last_y_q;
    rem_d    = rem_q;
    dq_d     = dq_q;
    cnt_d    = cnt_q;
    sat_d    = sat_q;
    alpha_d  = alpha_q;
    case (op_i)
      sdcm_pkg::OP_DIV_INIT: begin
        sat_d = (t_w >= d_w);
        rem_d = num_w[NW-1:QB];
        dq_d  = num_w[QB-1:0];
        cnt_d = CNT_INIT;
      end
      sdcm_pkg::OP_DIV_STEP: begin
        rem_d = ge_w ? r2_sub[TIME_BITS-1:0] : r2_w[TIME_BITS-1:0];
        dq_d  = {dq_q[QB-2:0], ge_w};
        if (cnt_q != '0) begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      sdcm_pkg::OP_ALPHA: begin
        alpha_d = sat_q ? 16'd0 : cos_rom[dq_q];
      end
      sdcm_pkg::OP_SUM_X: begin
        last_x_d = pos_w;
      end
      sdcm_pkg::OP_SUM_Y: begin
        last_y_d = pos_w;
      end
      sdcm_pkg::OP_TIME: begin
        tl_d = tl_q - $signed({1'b0, step_w});
        if (tl_d[TIME_BITS]) begin
          mode_d = opening_w ? sdcm_pkg::DOOR_OPEN : sdcm_pkg::DOOR_SHUT;
        end
      end
      sdcm_pkg::OP_REST: begin
        if (mode_q == sdcm_pkg::DOOR_SHUT) begin
          last_x_d = cfg_i.closed_x;
          last_y_d = cfg_i.closed_y;
        end else begin
          last_x_d = cfg_i.opened_x;
          last_y_d = cfg_i.opened_y;
        end
      end
      sdcm_pkg::OP_REQ: begin
        case (word_i.req_type)
          sdcm_pkg::REQ_OPEN: begin
            if (mode_q == sdcm_pkg::DOOR_SHUT) begin
              tl_d   = $signed({1'b0, d_w});
              mode_d = sdcm_pkg::DOOR_TO_OPEN;
            end else if (mode_q == sdcm_pkg::DOOR_TO_SHUT) begin
              tl_d   = rev_w[TIME_BITS] ? '0 : rev_w;
              mode_d = sdcm_pkg::DOOR_TO_OPEN;
            end
          end
          sdcm_pkg::REQ_CLOSE: begin
            if (mode_q == sdcm_pkg::DOOR_OPEN) begin
              tl_d   = $signed({1'b0, d_w});
              mode_d = sdcm_pkg::DOOR_TO_SHUT;
            end else if (mode_q == sdcm_pkg::DOOR_TO_OPEN) begin
              tl_d   = rev_w[TIME_BITS] ? '0 : rev_w;
              mode_d = sdcm_pkg::DOOR_TO_SHUT;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= sdcm_pkg::DOOR_SHUT;
      tl_q     <= '0;
      last_x_q <= '0;
      last_y_q <= '0;
    end else begin
      mode_q   <= mode_d;
      tl_q     <= tl_d;
      last_x_q <= last_x_d;
      last_y_q <= last_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    dq_q    <= dq_d;
    cnt_q   <= cnt_d;
    sat_q   <= sat_d;
    alpha_q <= alpha_d;
    if ((op_i == sdcm_pkg::OP_MUL_X) || (op_i == sdcm_pkg::OP_MUL_Y)) begin
      prod_q <= prod_d;
    end
  end

  assign stat_o.at_rest  = (mode_q == sdcm_pkg::DOOR_SHUT) ||
                           (mode_q == sdcm_pkg::DOOR_OPEN);
  assign stat_o.div_more = (cnt_q != '0);

  assign pos_o.door_x    = last_x_q;
  assign pos_o.door_y    = last_y_q;
  assign pos_o.door_mode = mode_q;

endmodule

@@ src/sliding_door_cosine_motion.sv @@
// channel | dir | handshake                 | word
// --------+-----+---------------------------+----------------------------------
// in      | in  | in_valid_i / in_ready_o   | in_word_i  (req_type, step_time)
// out     | out | out_valid_o / out_ready_i | out_word_o (door_x, door_y, door_mode)
// cfg     | in  | cfg_we_i, no wait         | cfg_idx_i, cfg_data_i
//
// a tick while moving runs from accept through the endpoint check, the bit-serial
// index divider, the weight lookup, multiply and sum for x and y and the time step
// to emit before the next word is taken; a tick at rest snaps to its endpoint
// reset puts the door closed at (0,0), duration 1000, no clearing pass
// the result register lets a new word in while a result waits; the sequencer
// holds at its emit step only if the previous result is still not taken

`include "sliding_door_cosine_motion_macros.svh"

module sliding_door_cosine_motion #(
  parameter int unsigned TIME_BITS       = sdcm_pkg::TIME_BITS,
  parameter int unsigned COS_TABLE_DEPTH = sdcm_pkg::COS_TABLE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  sdcm_pkg::in_word_t                in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output sdcm_pkg::out_word_t               out_word_o,
  input  logic                              cfg_we_i,
  input  logic [sdcm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sdcm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned PW = sdcm_pkg::PC_W;

  // program step addresses
  localparam logic [PW-1:0] ST_FETCH = 4'd0;
  localparam logic [PW-1:0] ST_DIV   = 4'd4;
  localparam logic [PW-1:0] ST_REST  = 4'd11;
  localparam logic [PW-1:0] ST_REQ   = 4'd12;
  localparam logic [PW-1:0] ST_EMIT  = 4'd13;
  localparam int unsigned   PROG_LEN = 14;

  // control store: op, jump condition, jump target, return to fetch
  localparam sdcm_pkg::uword_t PROGRAM [PROG_LEN] = '{
    '{sdcm_pkg::OP_TAKE,     sdcm_pkg::C_NO_INPUT, ST_FETCH, 1'b0}, // wait for a word
    '{sdcm_pkg::OP_NONE,     sdcm_pkg::C_NOT_TICK, ST_REQ,   1'b0}, // requests
    '{sdcm_pkg::OP_NONE,     sdcm_pkg::C_AT_REST,  ST_REST,  1'b0}, // tick at an endpoint
    '{sdcm_pkg::OP_DIV_INIT, sdcm_pkg::C_NEVER,    ST_FETCH, 1'b0}, // load dividend
    '{sdcm_pkg::OP_DIV_STEP, sdcm_pkg::C_DIV_MORE, ST_DIV,   1'b0}, // one quotient bit
    '{sdcm_pkg::OP_ALPHA,    sdcm_pkg::C_NEVER,    ST_FETCH, 1'b0}, // weight lookup
    '{sdcm_pkg::OP_MUL_X,    sdcm_pkg::C_NEVER,    ST_FETCH, 1'b0},
    '{sdcm_pkg::OP_SUM_X,    sdcm_pkg::C_NEVER,    ST_FETCH, 1'b0},
    '{sdcm_pkg::OP_MUL_Y,    sdcm_pkg::C_NEVER,    ST_FETCH, 1'b0},
    '{sdcm_pkg::OP_SUM_Y,    sdcm_pkg::C_NEVER,    ST_FETCH, 1'b0},
    '{sdcm_pkg::OP_TIME,     sdcm_pkg::C_ALWAYS,   ST_EMIT,  1'b0}, // count down, maybe stop
    '{sdcm_pkg::OP_REST,     sdcm_pkg::C_ALWAYS,   ST_EMIT,  1'b0}, // snap to endpoint
    '{sdcm_pkg::OP_REQ,      sdcm_pkg::C_NEVER,    ST_FETCH, 1'b0}, // start or reverse
    '{sdcm_pkg::OP_EMIT,     sdcm_pkg::C_OUT_BUSY, ST_EMIT,  1'b1}  // hand over result
  };

  // configuration registers
  sdcm_pkg::cfg_t      cfg_q;

  // sequencer
  logic [PW-1:0]       pc_q, pc_d;
  sdcm_pkg::uword_t    uw;
  logic                cond_hit;

  // latched input word and result register
  sdcm_pkg::in_word_t  in_q;
  logic                out_valid_q, out_valid_d;
  sdcm_pkg::out_word_t out_q;
  logic                out_busy;
  logic                out_load;

  sdcm_pkg::dp_stat_t  stat;
  sdcm_pkg::out_word_t pos;

  assign uw       = PROGRAM[pc_q];
  assign out_busy = out_valid_q && !out_ready_i;
  assign out_load = (uw.op == sdcm_pkg::OP_EMIT) && !out_busy;

  always_comb begin
    case (uw.cond)
      sdcm_pkg::C_NEVER:    cond_hit = 1'b0;
      sdcm_pkg::C_ALWAYS:   cond_hit = 1'b1;
      sdcm_pkg::C_NO_INPUT: cond_hit = !in_valid_i;
      sdcm_pkg::C_NOT_TICK: cond_hit = (in_q.req_type != sdcm_pkg::REQ_TICK);
      sdcm_pkg::C_AT_REST:  cond_hit = stat.at_rest;
      sdcm_pkg::C_DIV_MORE: cond_hit = stat.div_more;
      sdcm_pkg::C_OUT_BUSY: cond_hit = out_busy;
      default:              cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (cond_hit) begin
      pc_d = uw.target;
    end else if (uw.last) begin
      pc_d = ST_FETCH;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  // result register: cleared when taken, refilled at the emit step
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q                <= ST_FETCH;
      out_valid_q         <= 1'b0;
      cfg_q.closed_x      <= '0;
      cfg_q.closed_y      <= '0;
      cfg_q.opened_x      <= '0;
      cfg_q.opened_y      <= '0;
      cfg_q.move_duration <= sdcm_pkg::DURATION_RESET;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sdcm_pkg::REG_CLOSED_X:      cfg_q.closed_x      <= $signed(cfg_data_i);
          sdcm_pkg::REG_CLOSED_Y:      cfg_q.closed_y      <= $signed(cfg_data_i);
          sdcm_pkg::REG_OPENED_X:      cfg_q.opened_x      <= $signed(cfg_data_i);
          sdcm_pkg::REG_OPENED_Y:      cfg_q.opened_y      <= $signed(cfg_data_i);
          sdcm_pkg::REG_MOVE_DURATION: cfg_q.move_duration <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_word_i;
    end
    if (out_load) begin
      out_q <= pos;
    end
  end

  sdcm_datapath #(
    .TIME_BITS       (TIME_BITS),
    .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (uw.op),
    .cfg_i  (cfg_q),
    .word_i (in_q),
    .stat_o (stat),
    .pos_o  (pos)
  );

  assign in_ready_o  = (uw.op == sdcm_pkg::OP_TAKE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // the step counter never leaves the program
  `SDCM_ASSERT_NOW(a_pc_in_range, 1'b1, pc_q <= ST_EMIT, "step counter outside program")
  // one word is worked on at a time
  `SDCM_ASSERT_NEXT(a_one_word, in_valid_i && in_ready_o, !in_ready_o, "word taken while busy")
  // a fresh result only comes from the emit step
  `SDCM_ASSERT_NOW(a_emit_src, $rose(out_valid_q), $past(pc_q) == ST_EMIT, "stray result")

endmodule

@@ bench/tb_sliding_door_cosine_motion.sv @@
module tb_sliding_door_cosine_motion;
  timeunit 1ns;
  timeprecision 1ps;

  import sdcm_pkg::*;

  // request code the block has to ignore
  localparam logic [1:0] REQ_SPARE = 2'd3;

  localparam int          ROM_DEPTH       = COS_TABLE_DEPTH;
  localparam logic [63:0] HALF_TURN_Q30   = 64'd3373259426;  // pi in q30
  localparam int          SETTLE_CYCLES   = 30;
  localparam int          CYCLE_LIMIT     = 400000;
  localparam int          PHASES          = 12;
  localparam int          WORDS_PER_PHASE = 100;

  // one line of the directed table: either a word to send or a register write
  typedef enum logic { ROW_WORD, ROW_REG } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [2:0]  code;   // request for a word row, register index for a write row
    logic [15:0] arg;    // step time for a word row, write data for a write row
    logic        typed;  // expected result given in the row itself
    out_word_t   want;
  } plan_row_t;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  in_word_t              in_word_i  = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_word_t             out_word_o;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  sliding_door_cosine_motion dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // door predictor: own copy of the registers, the motion state and the weights
  // ---------------------------------------------------------------------------

  cfg_t               door_cfg    = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd1000};
  mode_e              door_mode_q = DOOR_SHUT;
  logic signed [16:0] time_left_q = '0;  // one sign bit over the time width
  logic signed [15:0] door_x_q    = '0;
  logic signed [15:0] door_y_q    = '0;
  logic [15:0]        weight_rom [ROM_DEPTH];

  out_word_t pending_doors [$];  // results still owed by the block, oldest first

  int  mismatches = 0;
  int  cycles     = 0;
  int  stall_left = 0;
  bit  idle_on    = 1'b1;
  out_word_t want;

  // (cos(pi*i/depth)+1)/2 in q1.15: q30 taylor series to the x^14 term with
  // truncating steps, mirrored past a quarter turn, rounded half up
  function automatic logic [15:0] cos_weight_q15(input int unsigned i);
    logic [63:0] ang;
    logic [63:0] sq;
    logic [63:0] term;
    longint      acc;
    longint      num;
    logic        mirror;
    mirror = (2 * i > ROM_DEPTH);
    ang    = (HALF_TURN_Q30 * (mirror ? ROM_DEPTH - i : i)) / ROM_DEPTH;
    sq     = (ang * ang) >> 30;
    term   = 64'd1 << 30;
    acc    = 64'sd1073741824;
    for (int k = 1; k <= 7; k++) begin
      term = (term * sq) >> 30;
      term = term / ((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (mirror) begin
      acc = -acc;
    end
    num = 64'sd1073741824 + acc + 64'sd32768;
    if (num < 0) begin
      return 16'd0;
    end
    num = num / 65536;
    if (num > 32768) begin
      num = 32768;
    end
    return num[15:0];
  endfunction

  // weighted mix of two coordinates, rounded half up, floor shift
  function automatic logic signed [15:0] blend(input logic signed [15:0] toward,
                                               input logic signed [15:0] from,
                                               input longint alpha);
    longint s;
    s = longint'(toward) * alpha + longint'(from) * (32768 - alpha) + 16384;
    return s >>> 15;
  endfunction

  function automatic void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    case (idx)
      REG_CLOSED_X:      door_cfg.closed_x      = val;
      REG_CLOSED_Y:      door_cfg.closed_y      = val;
      REG_OPENED_X:      door_cfg.opened_x      = val;
      REG_OPENED_Y:      door_cfg.opened_y      = val;
      REG_MOVE_DURATION: door_cfg.move_duration = val;
      default: ;
    endcase
  endfunction

  // one accepted word: update the door state and return the position it reports
  function automatic out_word_t advance_door(input in_word_t w);
    longint span;
    longint t;
    longint idx;
    longint alpha;
    longint back;
    // a zero travel time behaves as one
    span = (door_cfg.move_duration == '0) ? 1 : longint'(door_cfg.move_duration);
    case (w.req_type)
      REQ_TICK: begin
        if (door_mode_q == DOOR_SHUT) begin
          door_x_q = door_cfg.closed_x;
          door_y_q = door_cfg.closed_y;
        end else if (door_mode_q == DOOR_OPEN) begin
          door_x_q = door_cfg.opened_x;
          door_y_q = door_cfg.opened_y;
        end else begin
          // position from the time left before this tick
          t     = (time_left_q > 0) ? longint'(time_left_q) : 0;
          idx   = (t * ROM_DEPTH) / span;
          alpha = (idx < ROM_DEPTH) ? longint'(weight_rom[idx]) : 0;
          if (door_mode_q == DOOR_TO_OPEN) begin
            door_x_q = blend(door_cfg.opened_x, door_cfg.closed_x, alpha);
            door_y_q = blend(door_cfg.opened_y, door_cfg.closed_y, alpha);
          end else begin
            door_x_q = blend(door_cfg.closed_x, door_cfg.opened_x, alpha);
            door_y_q = blend(door_cfg.closed_y, door_cfg.opened_y, alpha);
          end
          time_left_q = longint'(time_left_q) - longint'(w.step_time);
          if (time_left_q < 0) begin
            door_mode_q = (door_mode_q == DOOR_TO_OPEN) ? DOOR_OPEN : DOOR_SHUT;
          end
        end
      end
      REQ_OPEN: begin
        if (door_mode_q == DOOR_SHUT) begin
          time_left_q = span;
          door_mode_q = DOOR_TO_OPEN;
        end else if (door_mode_q == DOOR_TO_SHUT) begin
          back        = span - longint'(time_left_q);
          time_left_q = (back < 0) ? 0 : back;
          door_mode_q = DOOR_TO_OPEN;
        end
      end
      REQ_CLOSE: begin
        if (door_mode_q == DOOR_OPEN) begin
          time_left_q = span;
          door_mode_q = DOOR_TO_SHUT;
        end else if (door_mode_q == DOOR_TO_OPEN) begin
          back        = span - longint'(time_left_q);
          time_left_q = (back < 0) ? 0 : back;
          door_mode_q = DOOR_TO_SHUT;
        end
      end
      default: ;  // spare code leaves everything alone
    endcase
    return '{door_x: door_x_q, door_y: door_y_q, door_mode: door_mode_q};
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic plan_row_t word_row(input logic [1:0] req, input logic [15:0] step);
    return '{kind: ROW_WORD, code: {1'b0, req}, arg: step, typed: 1'b0, want: '0};
  endfunction

  function automatic plan_row_t typed_row(input logic [1:0] req, input logic [15:0] step,
                                          input logic [15:0] x, input logic [15:0] y,
                                          input mode_e mode);
    return '{kind: ROW_WORD, code: {1'b0, req}, arg: step, typed: 1'b1,
             want: '{door_x: x, door_y: y, door_mode: mode}};
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [15:0] val);
    return '{kind: ROW_REG, code: idx, arg: val, typed: 1'b0, want: '0};
  endfunction

  // mostly full range, with the extremes and zero showing up often
  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // short travel times mostly, the limits and zero now and then
  function automatic logic [15:0] pick_duration();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hffff;
      3, 4, 5: return 16'($urandom_range(2, 64));
      default: return 16'($urandom_range(65, 3000));
    endcase
  endfunction

  // ticks sized to the travel time so moves run through all their stages
  function automatic in_word_t random_word();
    int unsigned roll;
    int unsigned span;
    in_word_t    w;
    roll = $urandom_range(0, 99);
    span = (door_cfg.move_duration == '0) ? 1 : door_cfg.move_duration;
    if (roll < 62) begin
      w.req_type = REQ_TICK;
    end else if (roll < 79) begin
      w.req_type = REQ_OPEN;
    end else if (roll < 96) begin
      w.req_type = REQ_CLOSE;
    end else begin
      w.req_type = REQ_SPARE;
    end
    case ($urandom_range(0, 9))
      0:       w.step_time = '0;
      1:       w.step_time = 16'($urandom_range(0, 65535));
      default: w.step_time = 16'($urandom_range(0, span / 3 + 1));
    endcase
    return w;
  endfunction

  // hold the word until the block takes it, with an optional gap in front
  task automatic push_word(input in_word_t w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // stop sending and let every owed result come out before touching registers
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_doors.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    set_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall bursts, in-order compare against owed results
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_doors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected word: x=%0d y=%0d mode=%0d", out_word_o.door_x,
                   out_word_o.door_y, out_word_o.door_mode);
        end
      end else begin
        want = pending_doors.pop_front();
        if (out_word_o.door_x !== want.door_x || out_word_o.door_y !== want.door_y ||
            out_word_o.door_mode !== want.door_mode) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: want x=%0d y=%0d mode=%0d, got x=%0d y=%0d mode=%0d",
                     want.door_x, want.door_y, want.door_mode, out_word_o.door_x,
                     out_word_o.door_y, out_word_o.door_mode);
          end
        end
      end
    end
    // stall bursts start only while idling is on
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_ready_i <= 1'b0;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // hang guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  plan_row_t plan [$];

  initial begin
    in_word_t  w;
    out_word_t got;

    for (int i = 0; i < ROM_DEPTH; i++) begin
      weight_rom[i] = cos_weight_q15(i);
    end

    // reset values: door closed at the origin, nothing configured yet
    plan.push_back(typed_row(REQ_TICK, 16'h0000, 16'h0000, 16'h0000, DOOR_SHUT));
    // close while closed is ignored
    plan.push_back(typed_row(REQ_CLOSE, 16'h0000, 16'h0000, 16'h0000, DOOR_SHUT));
    // spare code only reports
    plan.push_back(typed_row(REQ_SPARE, 16'hffff, 16'h0000, 16'h0000, DOOR_SHUT));
    // request items report the last position, here still the origin
    plan.push_back(typed_row(REQ_OPEN, 16'h0000, 16'h0000, 16'h0000, DOOR_TO_OPEN));
    plan.push_back(typed_row(REQ_OPEN, 16'h0000, 16'h0000, 16'h0000, DOOR_TO_OPEN));
    // full time left puts the weight index past the table, so weight zero
    plan.push_back(typed_row(REQ_TICK, 16'h0000, 16'h0000, 16'h0000, DOOR_TO_OPEN));

    // endpoints at opposite corners, longest travel time, door left mid-move
    plan.push_back(reg_row(REG_CLOSED_X, 16'h8000));
    plan.push_back(reg_row(REG_CLOSED_Y, 16'h7fff));
    plan.push_back(reg_row(REG_OPENED_X, 16'h7fff));
    plan.push_back(reg_row(REG_OPENED_Y, 16'h8000));
    plan.push_back(reg_row(REG_MOVE_DURATION, 16'hffff));
    plan.push_back(word_row(REQ_TICK, 16'h0000));
    // largest step finishes the move, the last moving tick is off the endpoint
    plan.push_back(word_row(REQ_TICK, 16'hffff));
    plan.push_back(typed_row(REQ_TICK, 16'h5555, 16'h7fff, 16'h8000, DOOR_OPEN));
    plan.push_back(word_row(REQ_OPEN, 16'h0000));
    plan.push_back(word_row(REQ_CLOSE, 16'haaaa));
    plan.push_back(word_row(REQ_TICK, 16'd1000));
    // reversal mid-move
    plan.push_back(word_row(REQ_OPEN, 16'h0000));
    plan.push_back(word_row(REQ_TICK, 16'd500));
    // shorter travel than the time left: reversal saturates at zero
    plan.push_back(reg_row(REG_MOVE_DURATION, 16'd16));
    plan.push_back(word_row(REQ_CLOSE, 16'h0000));
    plan.push_back(word_row(REQ_TICK, 16'h0000));
    plan.push_back(word_row(REQ_TICK, 16'h0001));
    plan.push_back(typed_row(REQ_TICK, 16'h0000, 16'h8000, 16'h7fff, DOOR_SHUT));
    // zero travel time acts as one
    plan.push_back(reg_row(REG_MOVE_DURATION, 16'd0));
    plan.push_back(word_row(REQ_OPEN, 16'h0000));
    plan.push_back(word_row(REQ_TICK, 16'h0000));
    plan.push_back(word_row(REQ_TICK, 16'h0001));
    plan.push_back(word_row(REQ_TICK, 16'h0001));
    plan.push_back(word_row(REQ_SPARE, 16'h0000));
    plan.push_back(word_row(REQ_CLOSE, 16'h0000));
    plan.push_back(word_row(REQ_TICK, 16'h5555));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        drain();
        write_reg(plan[i].code, plan[i].arg);
      end else begin
        w = '{req_type: plan[i].code[1:0], step_time: plan[i].arg};
        push_word(w);
        got = advance_door(w);
        pending_doors.push_back(plan[i].typed ? plan[i].want : got);
      end
    end

    // random phases, fresh endpoints and travel time each; a few phases
    // without idling in the middle and the last two fully busy
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      idle_on = (ph < PHASES - 2) && (ph % 4 != 3);
      write_reg(REG_CLOSED_X, pick_coord());
      write_reg(REG_CLOSED_Y, pick_coord());
      write_reg(REG_OPENED_X, pick_coord());
      write_reg(REG_OPENED_Y, pick_coord());
      write_reg(REG_MOVE_DURATION, pick_duration());
      repeat (WORDS_PER_PHASE) begin
        w = random_word();
        push_word(w);
        pending_doors.push_back(advance_door(w));
      end
    end

    // wait out every owed result plus a margin for anything extra
    drain();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/sdcm_pkg.sv
src/sdcm_datapath.sv
src/sliding_door_cosine_motion.sv
bench/tb_sliding_door_cosine_motion.sv
